@@ design/chash_pkg.sv @@
// ----------------------------------------------------------------------------
// chash_pkg
// Shared types and constants for the chunk coordinate hash table.
// ----------------------------------------------------------------------------
package chash_pkg;

	localparam int COORD_W  = 26;
	localparam int IDX_W    = 13;
	localparam int STATUS_W = 3;

	localparam int HOME_SLOTS_DEF  = 4096;
	localparam int SPILL_SLOTS_DEF = 1024;
	localparam int COORD_LIMIT_DEF = 33554432;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_CLAIMED   = 3'd1,
		ST_APPENDED  = 3'd2,
		ST_ABSENT    = 3'd3,
		ST_POOL_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} key_t;

	typedef struct packed {
		logic valid;
		key_t key;
	} home_word_t;

	// Per-cycle strobes from the sequencer to the table storage.
	typedef struct packed {
		logic home_we;
		logic home_re;
		logic hlink_we;
		logic spill_we;
		logic spill_re;
		logic slink_we;
	} mem_ctl_t;

endpackage

@@ design/chash_hash.sv @@
// ----------------------------------------------------------------------------
// chash_hash
// Registered home slot hash and coordinate range check for one item.
// ----------------------------------------------------------------------------
module chash_hash #(
	parameter int HOME_SLOTS  = chash_pkg::HOME_SLOTS_DEF,
	parameter int COORD_LIMIT = chash_pkg::COORD_LIMIT_DEF,
	localparam int HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [chash_pkg::COORD_W-1:0] coord_x,
	input  logic signed [chash_pkg::COORD_W-1:0] coord_y,
	input  logic signed [chash_pkg::COORD_W-1:0] coord_z,
	output logic [HW-1:0]                        home_s1,
	output logic                                 out_of_range_s1
);

	localparam logic signed [31:0] LIM     = 32'(COORD_LIMIT);
	localparam logic [HW-1:0]      HMASK   = HW'(HOME_SLOTS - 1);

	logic signed [31:0] xs, ys, zs;
	logic [31:0]        sum;
	logic               oor;

	always_comb begin
		xs  = 32'(coord_x);
		ys  = 32'(coord_y);
		zs  = 32'(coord_z);
		// 19x + 7y + 3z with 32-bit wraparound, built from shifts and adds.
		sum = (xs <<< 4) + (xs <<< 1) + xs
		    + (ys <<< 3) - ys
		    + (zs <<< 1) + zs;
		oor = (xs <= -LIM) || (xs >= LIM)
		   || (ys <= -LIM) || (ys >= LIM)
		   || (zs <= -LIM) || (zs >= LIM);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			home_s1         <= sum[HW-1:0] & HMASK;
			out_of_range_s1 <= oor;
		end
	end

endmodule

@@ design/chash_store.sv @@
// ----------------------------------------------------------------------------
// chash_store
// Home slot and overflow pool memories with registered read data.
// ----------------------------------------------------------------------------
module chash_store #(
	parameter int HOME_SLOTS  = chash_pkg::HOME_SLOTS_DEF,
	parameter int SPILL_SLOTS = chash_pkg::SPILL_SLOTS_DEF,
	localparam int HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1,
	localparam int SW = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1,
	localparam int LW = $clog2(SPILL_SLOTS + 1)
) (
	input  logic                  clk,
	input  chash_pkg::mem_ctl_t   ctl,
	input  logic [HW-1:0]         home_addr,
	input  chash_pkg::home_word_t home_wdata,
	input  logic [LW-1:0]         hlink_wdata,
	input  logic [SW-1:0]         spill_raddr,
	input  logic [SW-1:0]         spill_waddr,
	input  chash_pkg::key_t       spill_wdata,
	input  logic [SW-1:0]         slink_waddr,
	input  logic [LW-1:0]         slink_wdata,
	output chash_pkg::home_word_t home_rd_q,
	output logic [LW-1:0]         hlink_rd_q,
	output chash_pkg::key_t       spill_rd_q,
	output logic [LW-1:0]         slink_rd_q
);

	chash_pkg::home_word_t home_mem  [HOME_SLOTS];
	logic [LW-1:0]         hlink_mem [HOME_SLOTS];
	chash_pkg::key_t       spill_mem [SPILL_SLOTS];
	logic [LW-1:0]         slink_mem [SPILL_SLOTS];

	always_ff @(posedge clk) begin
		if (ctl.home_we) begin
			home_mem[home_addr] <= home_wdata;
		end
		if (ctl.home_re) begin
			home_rd_q <= home_mem[home_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.hlink_we) begin
			hlink_mem[home_addr] <= hlink_wdata;
		end
		if (ctl.home_re) begin
			hlink_rd_q <= hlink_mem[home_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.spill_we) begin
			spill_mem[spill_waddr] <= spill_wdata;
		end
		if (ctl.spill_re) begin
			spill_rd_q <= spill_mem[spill_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.slink_we) begin
			slink_mem[slink_waddr] <= slink_wdata;
		end
		if (ctl.spill_re) begin
			slink_rd_q <= slink_mem[spill_raddr];
		end
	end

endmodule

@@ design/chash_ctrl.sv @@
// ----------------------------------------------------------------------------
// chash_ctrl
// Sequencer for lookup, chain walk and append, with the shared key compare.
// ----------------------------------------------------------------------------
module chash_ctrl #(
	parameter int HOME_SLOTS  = chash_pkg::HOME_SLOTS_DEF,
	parameter int SPILL_SLOTS = chash_pkg::SPILL_SLOTS_DEF,
	localparam int HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1,
	localparam int SW = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1,
	localparam int LW = $clog2(SPILL_SLOTS + 1),
	localparam int IW = chash_pkg::IDX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input beat
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_op,
	input  chash_pkg::key_t       in_key,
	// Hash unit
	input  logic [HW-1:0]         home_s1,
	input  logic                  out_of_range_s1,
	// Storage
	output chash_pkg::mem_ctl_t   ctl,
	output logic [HW-1:0]         home_addr,
	output chash_pkg::home_word_t home_wdata,
	output logic [LW-1:0]         hlink_wdata,
	output logic [SW-1:0]         spill_raddr,
	output logic [SW-1:0]         spill_waddr,
	output chash_pkg::key_t       spill_wdata,
	output logic [SW-1:0]         slink_waddr,
	output logic [LW-1:0]         slink_wdata,
	input  chash_pkg::home_word_t home_rd_q,
	input  logic [LW-1:0]         hlink_rd_q,
	input  chash_pkg::key_t       spill_rd_q,
	input  logic [LW-1:0]         slink_rd_q,
	// Result beat
	output logic                  out_valid,
	input  logic                  out_ready,
	output chash_pkg::status_t    out_status,
	output logic [IW-1:0]         out_index
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_HASH  = 9'b000000100,
		S_HCHK  = 9'b000001000,
		S_SNEXT = 9'b000010000,
		S_SCHK  = 9'b000100000,
		S_MISS  = 9'b001000000,
		S_LINK  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	localparam logic [HW-1:0] HLAST  = HW'(HOME_SLOTS - 1);
	localparam logic [LW-1:0] SLOTS  = LW'(SPILL_SLOTS);
	localparam logic [LW-1:0] LINK1  = LW'(1);

	state_t             state_q, state_d;
	logic               op_q;
	chash_pkg::key_t    key_q;
	logic [HW-1:0]      clr_q;
	logic [LW-1:0]      link_q;
	logic [LW-1:0]      steps_q;
	logic [LW-1:0]      used_q;
	logic               tail_home_q;
	logic [SW-1:0]      tail_q;
	chash_pkg::status_t res_status_q;
	logic [IW-1:0]      res_index_q;
	logic               out_valid_q;
	chash_pkg::status_t out_status_q;
	logic [IW-1:0]      out_index_q;

	logic [LW-1:0]      spill_link_idx;
	logic [SW-1:0]      spill_idx;
	chash_pkg::key_t    cmp_key;
	logic               key_hit;
	logic               can_walk;
	logic               emit_go;
	logic [IW-1:0]      home_index;
	logic [IW-1:0]      spill_index;
	logic [IW-1:0]      new_index;

	always_comb begin
		spill_link_idx = link_q - LINK1;
		spill_idx      = SW'(spill_link_idx);
		// One comparator serves both the home slot and each chain entry.
		cmp_key        = (state_q == S_SCHK) ? spill_rd_q : home_rd_q.key;
		key_hit        = (cmp_key == key_q);
		can_walk       = (link_q != '0) && (spill_link_idx < used_q) && (steps_q < SLOTS);
		emit_go        = !out_valid_q || out_ready;
		home_index     = IW'(home_s1);
		spill_index    = IW'(32'(HOME_SLOTS) + 32'(spill_idx));
		new_index      = IW'(32'(HOME_SLOTS) + 32'(used_q));
	end

	always_comb begin
		state_d          = state_q;
		ctl              = '0;
		home_addr        = (state_q == S_CLEAR) ? clr_q : home_s1;
		home_wdata       = '0;
		hlink_wdata      = '0;
		spill_raddr      = spill_idx;
		spill_waddr      = SW'(used_q);
		spill_wdata      = key_q;
		slink_waddr      = SW'(used_q);
		slink_wdata      = '0;
		in_ready         = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.home_we = 1'b1;
				if (clr_q == HLAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (out_of_range_s1) begin
					state_d = S_EMIT;
				end else begin
					ctl.home_re = 1'b1;
					state_d     = S_HCHK;
				end
			end
			S_HCHK: begin
				if (!home_rd_q.valid) begin
					ctl.home_we      = 1'b1;
					ctl.hlink_we     = 1'b1;
					home_wdata.valid = 1'b1;
					home_wdata.key   = key_q;
					state_d          = S_EMIT;
				end else if (key_hit) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SNEXT;
				end
			end
			S_SNEXT: begin
				if (can_walk) begin
					ctl.spill_re = 1'b1;
					state_d      = S_SCHK;
				end else begin
					state_d = S_MISS;
				end
			end
			S_SCHK: begin
				state_d = key_hit ? S_EMIT : S_SNEXT;
			end
			S_MISS: begin
				if (op_q && (used_q < SLOTS)) begin
					ctl.spill_we = 1'b1;
					ctl.slink_we = 1'b1;
					state_d      = S_LINK;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_LINK: begin
				if (tail_home_q) begin
					ctl.hlink_we = 1'b1;
					hlink_wdata  = used_q + LINK1;
				end else begin
					ctl.slink_we = 1'b1;
					slink_waddr  = tail_q;
					slink_wdata  = used_q + LINK1;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + HW'(1);
			end
			if (state_q == S_LINK) begin
				used_q <= used_q + LINK1;
			end
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and walk registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q  <= in_op;
					key_q <= in_key;
				end
			end
			S_HASH: begin
				res_status_q <= chash_pkg::ST_ABSENT;
				res_index_q  <= '0;
			end
			S_HCHK: begin
				if (!home_rd_q.valid) begin
					res_status_q <= chash_pkg::ST_CLAIMED;
					res_index_q  <= home_index;
				end else if (key_hit) begin
					res_status_q <= chash_pkg::ST_FOUND;
					res_index_q  <= home_index;
				end
				link_q      <= hlink_rd_q;
				steps_q     <= '0;
				tail_home_q <= 1'b1;
			end
			S_SCHK: begin
				if (key_hit) begin
					res_status_q <= chash_pkg::ST_FOUND;
					res_index_q  <= spill_index;
				end else begin
					tail_home_q <= 1'b0;
					tail_q      <= spill_idx;
					link_q      <= slink_rd_q;
					steps_q     <= steps_q + LINK1;
				end
			end
			S_MISS: begin
				if (!op_q) begin
					res_status_q <= chash_pkg::ST_ABSENT;
					res_index_q  <= '0;
				end else if (used_q >= SLOTS) begin
					res_status_q <= chash_pkg::ST_POOL_FULL;
					res_index_q  <= '0;
				end else begin
					res_status_q <= chash_pkg::ST_APPENDED;
					res_index_q  <= new_index;
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					out_status_q <= res_status_q;
					out_index_q  <= res_index_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_index  = out_index_q;

endmodule

@@ design/chunk_coord_hash_table.sv @@
// ----------------------------------------------------------------------------
// chunk_coord_hash_table
// Spatial hash table that maps a signed 3D chunk coordinate to a table entry.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the home slot table, marking one slot
// empty per cycle, so s_axis_tready stays low until the sweep is done. Each
// item then hashes its coordinate as 19x + 7y + 3z, masked to the table
// size, and reads its home slot. An empty slot is claimed in either mode;
// otherwise the home slot and then its chain of overflow entries are
// compared against the coordinate, one entry at a time. A miss in find or
// insert mode appends a new overflow entry at the tail of the chain, or
// reports pool full if the pool has no free entry, and a miss in find only
// mode reports absent, as does any coordinate outside +/-(COORD_LIMIT-1).
// The block works on one item at a time; each chain step is a registered
// read of the single read port of the overflow memory followed by the
// shared key comparator. A miss adds a final probe and a miss state, and an
// append a tail link write. The result sits in an output register, so a
// new item is accepted while the previous result waits.
// ----------------------------------------------------------------------------
module chunk_coord_hash_table #(
	parameter int HOME_SLOTS  = chash_pkg::HOME_SLOTS_DEF,
	parameter int SPILL_SLOTS = chash_pkg::SPILL_SLOTS_DEF,
	parameter int COORD_LIMIT = chash_pkg::COORD_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request beat
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // coord_x[25:0], coord_y[51:26], coord_z[77:52], zero
	input  logic [0:0]  s_axis_tuser,  // op[0]
	// Result beat
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // entry_index[12:0], zero
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	localparam int HW = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
	localparam int SW = (SPILL_SLOTS > 1) ? $clog2(SPILL_SLOTS) : 1;
	localparam int LW = $clog2(SPILL_SLOTS + 1);
	localparam int CW = chash_pkg::COORD_W;
	localparam int IW = chash_pkg::IDX_W;

	chash_pkg::key_t       in_key;
	logic                  in_accept;
	logic [HW-1:0]         home_s1;
	logic                  out_of_range_s1;
	chash_pkg::mem_ctl_t   ctl;
	logic [HW-1:0]         home_addr;
	chash_pkg::home_word_t home_wdata;
	logic [LW-1:0]         hlink_wdata;
	logic [SW-1:0]         spill_raddr;
	logic [SW-1:0]         spill_waddr;
	chash_pkg::key_t       spill_wdata;
	logic [SW-1:0]         slink_waddr;
	logic [LW-1:0]         slink_wdata;
	chash_pkg::home_word_t home_rd_q;
	logic [LW-1:0]         hlink_rd_q;
	chash_pkg::key_t       spill_rd_q;
	logic [LW-1:0]         slink_rd_q;
	chash_pkg::status_t    out_status;
	logic [IW-1:0]         out_index;

	assign in_key.x  = s_axis_tdata[CW-1:0];
	assign in_key.y  = s_axis_tdata[2*CW-1:CW];
	assign in_key.z  = s_axis_tdata[3*CW-1:2*CW];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// The hash is registered on the accepting beat and used in the next cycle.
	chash_hash #(
		.HOME_SLOTS  (HOME_SLOTS),
		.COORD_LIMIT (COORD_LIMIT)
	) u_hash (
		.clk             (clk),
		.en              (in_accept),
		.coord_x         (in_key.x),
		.coord_y         (in_key.y),
		.coord_z         (in_key.z),
		.home_s1         (home_s1),
		.out_of_range_s1 (out_of_range_s1)
	);

	chash_ctrl #(
		.HOME_SLOTS  (HOME_SLOTS),
		.SPILL_SLOTS (SPILL_SLOTS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_op           (s_axis_tuser[0]),
		.in_key          (in_key),
		.home_s1         (home_s1),
		.out_of_range_s1 (out_of_range_s1),
		.ctl             (ctl),
		.home_addr       (home_addr),
		.home_wdata      (home_wdata),
		.hlink_wdata     (hlink_wdata),
		.spill_raddr     (spill_raddr),
		.spill_waddr     (spill_waddr),
		.spill_wdata     (spill_wdata),
		.slink_waddr     (slink_waddr),
		.slink_wdata     (slink_wdata),
		.home_rd_q       (home_rd_q),
		.hlink_rd_q      (hlink_rd_q),
		.spill_rd_q      (spill_rd_q),
		.slink_rd_q      (slink_rd_q),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_status      (out_status),
		.out_index       (out_index)
	);

	// Home slots carry a valid flag; overflow entries are valid below the
	// fill count kept by the sequencer, so they need no clearing.
	chash_store #(
		.HOME_SLOTS  (HOME_SLOTS),
		.SPILL_SLOTS (SPILL_SLOTS)
	) u_store (
		.clk         (clk),
		.ctl         (ctl),
		.home_addr   (home_addr),
		.home_wdata  (home_wdata),
		.hlink_wdata (hlink_wdata),
		.spill_raddr (spill_raddr),
		.spill_waddr (spill_waddr),
		.spill_wdata (spill_wdata),
		.slink_waddr (slink_waddr),
		.slink_wdata (slink_wdata),
		.home_rd_q   (home_rd_q),
		.hlink_rd_q  (hlink_rd_q),
		.spill_rd_q  (spill_rd_q),
		.slink_rd_q  (slink_rd_q)
	);

	assign m_axis_tdata = {3'b000, out_index};
	assign m_axis_tuser = out_status;

endmodule
